// File: sv/triangle_height_rasterizer_core_macros.svh
// assertion macros for the triangle height rasterizer
`ifndef TRIANGLE_HEIGHT_RASTERIZER_CORE_MACROS_SVH
`define TRIANGLE_HEIGHT_RASTERIZER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define THR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define THR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define THR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define THR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/thr_pkg.sv
// shared constants and request codes for the triangle height rasterizer
package thr_pkg;
    localparam int COORD_W  = 20;
    localparam int Z_W      = 16;
    localparam int CS_W     = 16;
    localparam int CNT_W    = 13;
    localparam int IDX_IN_W = 6;

    localparam logic [CS_W-1:0]  CELL_SIZE_RESET = 16'd5000;
    localparam logic [Z_W-1:0]   EMPTY_CELL      = 16'hFFFF;
    localparam logic [CNT_W-1:0] COUNT_MAX       = 13'd8191;

    typedef enum logic [1:0] {
        REQ_RASTER = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;
endpackage

// File: sv/triangle_height_rasterizer_core.sv
// triangle height rasterizer: height grid in one ram, cell walk pipeline, clear sweep
//
// input transactions on s_* carry a request kind in s_tuser: rasterize a triangle,
// read one cell, or clear the grid. every request returns exactly one result
// transaction on m_* (cell height in the low 16 bits, cells written above it).
// the user must write cell_size through cfg_wr_en / cfg_wr_data only while the block
// is idle; the block does not enforce it. a request is taken only when the engine is
// idle, one at a time. rasterize: four bound divisions on a shared radix-2 divider,
// then the base corner products, then one box cell per cycle through a three-stage
// edge test pipeline that writes the ram, then a drain of that pipeline. read: ram
// read register, then result. clear: one ram entry per cycle. after reset the same
// sweep runs and s_tready stays low until it ends.
// the result sits in an output register; when the receiver stalls, a new request
// may still be accepted, but its result waits until the register is free.
module triangle_height_rasterizer_core #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,   // cell_size
    input  logic         s_tvalid,
    output logic         s_tready,
    // x0, y0, z0, x1, y1, z1, x2, y2, z2, read_row, read_col, zero pad
    input  logic [183:0] s_tdata,
    input  logic [1:0]   s_tuser,       // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata        // cell_height, cells_written, zero pad
);
`include "triangle_height_rasterizer_core_macros.svh"

    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XCW   = $clog2(GRID_X + 1);
    localparam int YCW   = $clog2(GRID_Y + 1);
    localparam int PW    = ((XCW > YCW) ? XCW : YCW) + thr_pkg::CS_W;
    localparam int DFW   = ((PW > thr_pkg::COORD_W) ? PW : thr_pkg::COORD_W) + 2;
    localparam int EW    = thr_pkg::COORD_W + 1;
    localparam int PRW   = DFW + EW;
    localparam int DVW   = thr_pkg::COORD_W + 1;
    localparam int DCW   = $clog2(DVW);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_BASE  = 8'b0000_1000,
        ST_WALK  = 8'b0001_0000,
        ST_DRAIN = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] cell_size_reg;

    // input fields
    logic signed [19:0] in_x [3];
    logic signed [19:0] in_y [3];
    logic signed [15:0] in_z [3];
    logic [5:0] in_row, in_col;
    logic       in_acc;

    assign in_x[0] = s_tdata[19:0];
    assign in_y[0] = s_tdata[39:20];
    assign in_z[0] = s_tdata[55:40];
    assign in_x[1] = s_tdata[75:56];
    assign in_y[1] = s_tdata[95:76];
    assign in_z[1] = s_tdata[111:96];
    assign in_x[2] = s_tdata[131:112];
    assign in_y[2] = s_tdata[151:132];
    assign in_z[2] = s_tdata[167:152];
    assign in_row  = s_tdata[173:168];
    assign in_col  = s_tdata[179:174];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    function automatic logic signed [19:0] min3c(input logic signed [19:0] a,
                                                 input logic signed [19:0] b,
                                                 input logic signed [19:0] c);
        logic signed [19:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [19:0] max3c(input logic signed [19:0] a,
                                                 input logic signed [19:0] b,
                                                 input logic signed [19:0] c);
        logic signed [19:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [XCW-1:0] clamp_x(input logic [DVW-1:0] q);
        return (q > DVW'(GRID_X)) ? XCW'(GRID_X) : q[XCW-1:0];
    endfunction

    function automatic logic [YCW-1:0] clamp_y(input logic [DVW-1:0] q);
        return (q > DVW'(GRID_Y)) ? YCW'(GRID_Y) : q[YCW-1:0];
    endfunction

    // dividends for the bound divisions, negative ones give quotient zero
    logic signed [DVW-1:0] lo_x_s, hi_x_s, lo_y_s, hi_y_s;
    logic [DVW-1:0] dvd_in [4];

    always_comb begin
        lo_x_s = DVW'(min3c(in_x[0], in_x[1], in_x[2]));
        hi_x_s = DVW'(max3c(in_x[0], in_x[1], in_x[2])) + $signed({5'd0, cell_size_reg});
        lo_y_s = DVW'(min3c(in_y[0], in_y[1], in_y[2]));
        hi_y_s = DVW'(max3c(in_y[0], in_y[1], in_y[2])) + $signed({5'd0, cell_size_reg});
        dvd_in[0] = (lo_x_s > 0) ? lo_x_s : '0;
        dvd_in[1] = (hi_x_s > 0) ? hi_x_s : '0;
        dvd_in[2] = (lo_y_s > 0) ? lo_y_s : '0;
        dvd_in[3] = (hi_y_s > 0) ? hi_y_s : '0;
    end

    // control and triangle registers
    logic [DVW-1:0]     dvd_reg [4];
    logic [1:0]         div_sel_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic [15:0]        div_rem_reg;
    logic [DVW-1:0]     div_quo_reg;
    logic [XCW-1:0]     jlo_reg, jhi_reg, j_reg;
    logic [YCW-1:0]     klo_reg, khi_reg, k_reg;
    logic [PW-1:0]      px_reg, py_reg, py_base_reg;
    logic signed [19:0] bx_reg [3];
    logic signed [19:0] by_reg [3];
    logic signed [EW-1:0] cx_reg [3];
    logic signed [EW-1:0] cy_reg [3];
    logic [15:0]        zmin_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               clr_req_reg;
    logic               rd_inrange_reg;
    logic [15:0]        rd_data_reg;
    logic [15:0]        res_height_reg;
    logic [thr_pkg::CNT_W-1:0] count_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;

    // edge test pipeline
    logic                  p1_v_reg, p2_v_reg, p3_v_reg;
    logic [AW-1:0]         p1_addr_reg, p2_addr_reg, p3_addr_reg;
    logic signed [DFW-1:0] p1_dx_reg [3];
    logic signed [DFW-1:0] p1_dy_reg [3];
    logic signed [PRW-1:0] p2_a_reg [3];
    logic signed [PRW-1:0] p2_b_reg [3];
    logic signed [PRW-1:0] p3_a_reg [3];
    logic signed [PRW-1:0] p3_b_reg [3];

    // divider step
    logic [16:0]    rem_sh;
    logic           q_bit;
    logic [15:0]    rem_new;
    logic [DVW-1:0] quo_new;
    logic           div_last;

    always_comb begin
        rem_sh   = {div_rem_reg, div_quo_reg[DVW-1]};
        q_bit    = (rem_sh >= {1'b0, cell_size_reg});
        rem_new  = q_bit ? 16'(rem_sh - {1'b0, cell_size_reg}) : rem_sh[15:0];
        quo_new  = {div_quo_reg[DVW-2:0], q_bit};
        div_last = (div_cnt_reg == DCW'(DVW - 1));
    end

    // walk control
    logic k_last, j_last, box_empty;
    assign k_last    = (k_reg == khi_reg - YCW'(1));
    assign j_last    = (j_reg == jhi_reg - XCW'(1));
    assign box_empty = (jlo_reg >= jhi_reg) || (klo_reg >= khi_reg);

    // inside test: sign of a - b for each edge
    logic any_neg, any_pos, p3_inside;
    always_comb begin
        any_neg = 1'b0;
        any_pos = 1'b0;
        for (int e = 0; e < 3; e++) begin
            any_neg = any_neg || (p3_a_reg[e] < p3_b_reg[e]);
            any_pos = any_pos || (p3_a_reg[e] > p3_b_reg[e]);
        end
        p3_inside = !(any_neg && any_pos);
    end

    // ram ports
    logic [15:0]   mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          rd_inrange;

    always_comb begin
        mem_we    = (state_reg == ST_CLEAR) || (p3_v_reg && p3_inside);
        mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : p3_addr_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? thr_pkg::EMPTY_CELL : zmin_reg;
        rd_inrange = (32'(in_row) < GRID_X) && (32'(in_col) < GRID_Y);
        rd_en     = in_acc && (s_tuser == thr_pkg::REQ_READ) && rd_inrange;
        rd_addr   = AW'(32'(in_row) * GRID_Y + 32'(in_col));
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = clr_req_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (s_tuser)
                        thr_pkg::REQ_RASTER:
                            state_next = (cell_size_reg == '0) ? ST_DONE : ST_DIV;
                        thr_pkg::REQ_READ:  state_next = ST_READ;
                        thr_pkg::REQ_CLEAR: state_next = ST_CLEAR;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_last && (div_sel_reg == 2'd3)) begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:  state_next = box_empty ? ST_DONE : ST_WALK;
            ST_WALK: begin
                if (k_last && j_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!p1_v_reg && !p2_v_reg && !p3_v_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:  state_next = ST_DONE;
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_req_reg   <= 1'b0;
            cell_size_reg <= thr_pkg::CELL_SIZE_RESET;
            m_tvalid_reg  <= 1'b0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cell_size_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end else begin
                clr_addr_reg <= '0;
            end
            if (in_acc) begin
                clr_req_reg <= (s_tuser == thr_pkg::REQ_CLEAR);
            end
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            p1_v_reg <= (state_reg == ST_WALK);
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            res_height_reg <= '0;
            count_reg      <= '0;
            zmin_reg       <= 16'(min3c(20'(in_z[0]), 20'(in_z[1]), 20'(in_z[2])));
            for (int v = 0; v < 4; v++) begin
                dvd_reg[v] <= dvd_in[v];
            end
            div_sel_reg <= 2'd0;
            div_cnt_reg <= '0;
            div_rem_reg <= '0;
            div_quo_reg <= dvd_in[0];
            // edge n runs from vertex n to vertex n+1 mod 3, based at the latter
            bx_reg[0] <= in_x[1];
            by_reg[0] <= in_y[1];
            bx_reg[1] <= in_x[2];
            by_reg[1] <= in_y[2];
            bx_reg[2] <= in_x[0];
            by_reg[2] <= in_y[0];
            cx_reg[0] <= EW'(in_x[0]) - EW'(in_x[1]);
            cy_reg[0] <= EW'(in_y[0]) - EW'(in_y[1]);
            cx_reg[1] <= EW'(in_x[1]) - EW'(in_x[2]);
            cy_reg[1] <= EW'(in_y[1]) - EW'(in_y[2]);
            cx_reg[2] <= EW'(in_x[2]) - EW'(in_x[0]);
            cy_reg[2] <= EW'(in_y[2]) - EW'(in_y[0]);
            rd_inrange_reg <= rd_inrange;
        end

        if (state_reg == ST_DIV) begin
            if (div_last) begin
                case (div_sel_reg)
                    2'd0:    jlo_reg <= clamp_x(quo_new);
                    2'd1:    jhi_reg <= clamp_x(quo_new);
                    2'd2:    klo_reg <= clamp_y(quo_new);
                    default: khi_reg <= clamp_y(quo_new);
                endcase
                div_sel_reg <= div_sel_reg + 2'd1;
                div_cnt_reg <= '0;
                div_rem_reg <= '0;
                div_quo_reg <= dvd_reg[div_sel_reg + 2'd1];
            end else begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
                div_rem_reg <= rem_new;
                div_quo_reg <= quo_new;
            end
        end

        if (state_reg == ST_BASE) begin
            px_reg      <= PW'(jlo_reg) * PW'(cell_size_reg);
            py_reg      <= PW'(klo_reg) * PW'(cell_size_reg);
            py_base_reg <= PW'(klo_reg) * PW'(cell_size_reg);
            j_reg       <= jlo_reg;
            k_reg       <= klo_reg;
        end

        if (state_reg == ST_WALK) begin
            if (k_last) begin
                k_reg  <= klo_reg;
                py_reg <= py_base_reg;
                j_reg  <= j_reg + XCW'(1);
                px_reg <= px_reg + PW'(cell_size_reg);
            end else begin
                k_reg  <= k_reg + YCW'(1);
                py_reg <= py_reg + PW'(cell_size_reg);
            end
        end

        // stage 1: corner relative to each edge base
        p1_addr_reg <= AW'(32'(j_reg) * GRID_Y + 32'(k_reg));
        for (int e = 0; e < 3; e++) begin
            p1_dx_reg[e] <= $signed(DFW'(px_reg)) - DFW'(bx_reg[e]);
            p1_dy_reg[e] <= $signed(DFW'(py_reg)) - DFW'(by_reg[e]);
        end
        // stage 2: the two cross product terms
        p2_addr_reg <= p1_addr_reg;
        for (int e = 0; e < 3; e++) begin
            p2_a_reg[e] <= PRW'(p1_dx_reg[e]) * PRW'(cy_reg[e]);
            p2_b_reg[e] <= PRW'(cx_reg[e]) * PRW'(p1_dy_reg[e]);
        end
        // stage 3: compare, write and count
        p3_addr_reg <= p2_addr_reg;
        for (int e = 0; e < 3; e++) begin
            p3_a_reg[e] <= p2_a_reg[e];
            p3_b_reg[e] <= p2_b_reg[e];
        end
        if (p3_v_reg && p3_inside && (count_reg != thr_pkg::COUNT_MAX)) begin
            count_reg <= count_reg + thr_pkg::CNT_W'(1);
        end

        if (state_reg == ST_READ) begin
            res_height_reg <= rd_inrange_reg ? rd_data_reg : thr_pkg::EMPTY_CELL;
        end

        if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {3'd0, count_reg, res_height_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `THR_ASSERT_IMP(a_idle_pipe_empty, aclk, aresetn, s_tready,
        !p1_v_reg && !p2_v_reg && !p3_v_reg, "cell pipeline busy while idle")
    `THR_ASSERT_IMP(a_write_state, aclk, aresetn, mem_we,
        state_reg == ST_CLEAR || state_reg == ST_WALK || state_reg == ST_DRAIN,
        "grid written outside clear or walk")
    `THR_ASSERT_NXT(a_clear_start, aclk, aresetn,
        s_tvalid && s_tready && s_tuser == thr_pkg::REQ_CLEAR,
        state_reg == ST_CLEAR, "clear request did not start sweep")

endmodule

// File: tb/thr_checker.sv
// result checker for the triangle height rasterizer: watches both streams and predicts results
module thr_checker #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [183:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    output int           pending,
    output int           fail_count
);
    logic [thr_pkg::Z_W-1:0]  height_map [GRID_X*GRID_Y];
    logic [thr_pkg::CS_W-1:0] cell_edge;
    logic [31:0]              expected_results [$];

    assign pending = expected_results.size();

    function automatic longint edge_fn(longint px, longint py, longint ax, longint ay,
                                       longint bx, longint by);
        return (px - bx) * (ay - by) - (ax - bx) * (py - by);
    endfunction

    // walk the clipped bounding box, update the grid copy, return the write count
    function automatic logic [thr_pkg::CNT_W-1:0] rasterize(logic [183:0] d);
        longint vx [3];
        longint vy [3];
        longint vz [3];
        longint cs, xmin, xmax, ymin, ymax, zmin, jlo, jhi, klo, khi, px, py;
        longint e1, e2, e3;
        logic [thr_pkg::CNT_W-1:0] cnt;
        bit neg, pos;
        cnt = '0;
        for (int i = 0; i < 3; i++) begin
            vx[i] = longint'($signed(d[56*i +: 20]));
            vy[i] = longint'($signed(d[56*i + 20 +: 20]));
            vz[i] = longint'($signed(d[56*i + 40 +: 16]));
        end
        cs = longint'(cell_edge);
        if (cs == 0) return cnt;
        xmin = vx[0]; xmax = vx[0]; ymin = vy[0]; ymax = vy[0]; zmin = vz[0];
        for (int i = 1; i < 3; i++) begin
            if (vx[i] < xmin) xmin = vx[i];
            if (vx[i] > xmax) xmax = vx[i];
            if (vy[i] < ymin) ymin = vy[i];
            if (vy[i] > ymax) ymax = vy[i];
            if (vz[i] < zmin) zmin = vz[i];
        end
        jlo = xmin / cs;
        jhi = (xmax + cs) / cs;
        klo = ymin / cs;
        khi = (ymax + cs) / cs;
        if (jlo < 0) jlo = 0;
        if (klo < 0) klo = 0;
        if (jhi > GRID_X) jhi = GRID_X;
        if (khi > GRID_Y) khi = GRID_Y;
        for (longint j = jlo; j < jhi; j++) begin
            for (longint k = klo; k < khi; k++) begin
                px = j * cs;
                py = k * cs;
                e1 = edge_fn(px, py, vx[0], vy[0], vx[1], vy[1]);
                e2 = edge_fn(px, py, vx[1], vy[1], vx[2], vy[2]);
                e3 = edge_fn(px, py, vx[2], vy[2], vx[0], vy[0]);
                neg = (e1 < 0) || (e2 < 0) || (e3 < 0);
                pos = (e1 > 0) || (e2 > 0) || (e3 > 0);
                if (!(neg && pos)) begin
                    height_map[j*GRID_Y + k] = zmin[thr_pkg::Z_W-1:0];
                    if (cnt != thr_pkg::COUNT_MAX) cnt++;
                end
            end
        end
        return cnt;
    endfunction

    function automatic logic [31:0] predict_result(thr_pkg::req_type_t req,
                                                   logic [183:0] d);
        logic [thr_pkg::Z_W-1:0]   height;
        logic [thr_pkg::CNT_W-1:0] written;
        int row, col;
        height  = '0;
        written = '0;
        case (req)
            thr_pkg::REQ_RASTER: written = rasterize(d);
            thr_pkg::REQ_READ: begin
                row = d[173:168];
                col = d[179:174];
                if (row < GRID_X && col < GRID_Y) height = height_map[row*GRID_Y + col];
                else height = thr_pkg::EMPTY_CELL;
            end
            thr_pkg::REQ_CLEAR: foreach (height_map[i]) height_map[i] = thr_pkg::EMPTY_CELL;
            default: ;
        endcase
        return {3'b000, written, height};
    endfunction

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            foreach (height_map[i]) height_map[i] = thr_pkg::EMPTY_CELL;
            cell_edge = thr_pkg::CELL_SIZE_RESET;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) cell_edge = cfg_wr_data;
            // results leave before a new request in the same cycle can add one
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %h", m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[15:0] !== want[15:0] || m_tdata[28:16] !== want[28:16]
                        || m_tdata[31:29] !== want[31:29]) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: height exp %0d got %0d, written exp %0d got %0d",
                                     $signed(want[15:0]), $signed(m_tdata[15:0]),
                                     want[28:16], m_tdata[28:16]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    predict_result(thr_pkg::req_type_t'(s_tuser), s_tdata));
        end
    end
endmodule

// File: tb/tb_top.sv
// testbench top for the triangle height rasterizer: stimulus, stalls and verdict
module tb_top;

    localparam longint CYCLE_LIMIT = 40000000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [15:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [183:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    int           pending;
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           cur_cell;
    longint       cycles;

    triangle_height_rasterizer_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    thr_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .fail_count(fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL triangle_height_rasterizer_core");
            $finish;
        end
    end

    function automatic logic [19:0] clamp20(longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[19:0];
    endfunction

    function automatic logic [183:0] pack_tri(longint x0, longint y0, longint z0,
                                              longint x1, longint y1, longint z1,
                                              longint x2, longint y2, longint z2);
        return {16'h0, z2[15:0], clamp20(y2), clamp20(x2), z1[15:0], clamp20(y1),
                clamp20(x1), z0[15:0], clamp20(y0), clamp20(x0)};
    endfunction

    function automatic logic [183:0] pack_read(int row, int col);
        logic [183:0] d;
        d = 184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        d[179:168] = {col[5:0], row[5:0]};
        d[183:180] = '0;
        return d;
    endfunction

    task automatic send(thr_pkg::req_type_t req, logic [183:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic set_cell_size(int cs);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cs[15:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_cell = cs;
        @(posedge aclk);
    endtask

    // mostly small triangles near the grid, some spanning the whole coordinate range
    task automatic random_triangle();
        longint bx, by, sp;
        longint v [6];
        int mode;
        mode = $urandom_range(99);
        if (mode < 8) begin
            foreach (v[i]) v[i] = $signed(20'($urandom));
        end else begin
            bx = longint'($urandom_range(70)) * cur_cell - 3 * cur_cell
                 + $urandom_range(cur_cell - 1);
            by = longint'($urandom_range(70)) * cur_cell - 3 * cur_cell
                 + $urandom_range(cur_cell - 1);
            sp = longint'(cur_cell) * $urandom_range(4);
            foreach (v[i]) v[i] = (i % 2 ? by : bx) + $urandom_range(2 * sp) - sp;
            if (mode < 14) begin
                // collinear vertices
                v[4] = 2 * v[2] - v[0];
                v[5] = 2 * v[3] - v[1];
            end
        end
        send(thr_pkg::REQ_RASTER, pack_tri(v[0], v[1], $signed(16'($urandom)), v[2], v[3],
                                  $signed(16'($urandom)), v[4], v[5], $signed(16'($urandom))));
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(999);
            if (r < 560) random_triangle();
            else if (r < 920)
                send(thr_pkg::REQ_READ, pack_read($urandom_range(63), $urandom_range(63)));
            else if (r < 940)
                send(thr_pkg::REQ_CLEAR, pack_read($urandom_range(63), $urandom_range(63)));
            else if (r < 960)
                send(thr_pkg::REQ_NONE,
                     {4'h0, 180'($urandom) ^ 180'({6{$urandom}})});
            else
                send(thr_pkg::REQ_READ,
                     pack_read($urandom_range(1) * 63, $urandom_range(1) * 63));
        end
    endtask

    initial begin
        int cell_sizes [6];
        int idle_modes [4][2];
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = thr_pkg::REQ_NONE;
        m_tready       = 1'b1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_cell       = 5000;
        cycles         = 0;
        cell_sizes = '{5000, 1, 65535, 5000, 0, 257};
        cell_sizes[3] = $urandom_range(64000, 2);
        idle_modes = '{'{0, 0}, '{72, 0}, '{0, 72}, '{23, 23}};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty reads, corners, extremes, degenerate shapes, clear, no-op
        send(thr_pkg::REQ_READ, pack_read(0, 0));
        send(thr_pkg::REQ_READ, pack_read(63, 63));
        send(thr_pkg::REQ_RASTER, pack_tri(0, 0, 7, 20000, 0, -3, 0, 20000, 100));
        send(thr_pkg::REQ_READ, pack_read(0, 0));
        send(thr_pkg::REQ_READ, pack_read(4, 0));
        send(thr_pkg::REQ_RASTER,
             pack_tri(-50000, -50000, 1, -10000, -50000, 2, -50000, -10000, 3));
        send(thr_pkg::REQ_RASTER, pack_tri(30000, 30000, 5, 30000, 30000, 6, 30000, 30000, 9));
        send(thr_pkg::REQ_RASTER, pack_tri(0, 0, 11, 50000, 50000, 12, 100000, 100000, 13));
        send(thr_pkg::REQ_READ, pack_read(6, 6));
        send(thr_pkg::REQ_RASTER, pack_tri(-524288, -524288, -32768, 524287, -524288, 32767,
                                           0, 524287, 0));
        send(thr_pkg::REQ_READ, pack_read(63, 0));
        send(thr_pkg::REQ_RASTER, pack_tri(524287, 524287, 32767, -524288, 524287, 32767,
                                           524287, -524288, 32767));
        send(thr_pkg::REQ_READ, pack_read(63, 63));
        send(thr_pkg::REQ_NONE, {4'h0, {180{1'b1}}});
        send(thr_pkg::REQ_CLEAR, '0);
        send(thr_pkg::REQ_READ, pack_read(10, 10));
        send(thr_pkg::REQ_RASTER, pack_tri(315000, 0, -1, 320000, 315000, -2, 0, 320000, -5));
        send(thr_pkg::REQ_READ, pack_read(63, 1));

        for (int p = 0; p < 6; p++) begin
            if (p > 0) set_cell_size(cell_sizes[p]);
            for (int m = 0; m < 4; m++) begin
                send_idle_pct  = idle_modes[(m + p) % 4][0];
                recv_stall_pct = idle_modes[(m + p) % 4][1];
                random_phase(72);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS triangle_height_rasterizer_core");
        end else begin
            $display("FAIL triangle_height_rasterizer_core");
        end
        $finish;
    end
endmodule
